[hdl/assert_macros.svh]
// Assertion helpers for the RTL that checks itself.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/iou_pkg.sv]
package iou_pkg;

  // request codes
  typedef enum logic [1:0] {
    REQ_CLEAR  = 2'd0,
    REQ_APPEND = 2'd1,
    REQ_SCORE  = 2'd2
  } req_t;

  // fixed field widths
  localparam int COORD_W = 14;
  localparam int SIZE_W  = 12;
  localparam int INDEX_W = 6;
  localparam int COST_W  = 17;

  // doubled-coordinate geometry widths
  localparam int GEO_W  = 17;  // 2*c +- s, with headroom for the overlap difference
  localparam int SPAN_W = 13;  // overlap length, at most 2*4095
  localparam int AREA_W = 24;  // w*h
  localparam int I4_W   = 26;  // overlap area in doubled units
  localparam int U4_W   = 27;  // union area in doubled units

  // stored box
  typedef struct packed {
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_t;

  // word tag carried down the pipeline
  typedef struct packed {
    logic               valid;
    logic [INDEX_W-1:0] idx;
    logic               last;
  } tag_t;

  // low side of a box along one axis in doubled units
  function automatic logic signed [GEO_W-1:0] span_lo(logic signed [COORD_W-1:0] c,
                                                      logic [SIZE_W-1:0] s);
    logic signed [GEO_W-1:0] c2;
    logic signed [GEO_W-1:0] sx;
    c2 = GEO_W'(c);
    sx = GEO_W'(s);
    return (c2 <<< 1) - sx;
  endfunction

  // high side of a box along one axis in doubled units
  function automatic logic signed [GEO_W-1:0] span_hi(logic signed [COORD_W-1:0] c,
                                                      logic [SIZE_W-1:0] s);
    logic signed [GEO_W-1:0] c2;
    logic signed [GEO_W-1:0] sx;
    c2 = GEO_W'(c);
    sx = GEO_W'(s);
    return (c2 <<< 1) + sx;
  endfunction

  // overlap length of two intervals, clipped at zero
  function automatic logic [SPAN_W-1:0] overlap(logic signed [GEO_W-1:0] lo_a,
                                                logic signed [GEO_W-1:0] hi_a,
                                                logic signed [GEO_W-1:0] lo_b,
                                                logic signed [GEO_W-1:0] hi_b);
    logic signed [GEO_W-1:0] hi;
    logic signed [GEO_W-1:0] lo;
    logic signed [GEO_W-1:0] diff;
    hi   = (hi_a < hi_b) ? hi_a : hi_b;
    lo   = (lo_a > lo_b) ? lo_a : lo_b;
    diff = hi - lo;
    return (diff < 0) ? '0 : diff[SPAN_W-1:0];
  endfunction

endpackage

[hdl/iou_cost_matrix_core.sv]
// Channel   Handshake          Payload
// -------   ----------------   ---------------------------------------------
// request   start / busy       req_type, center_x, center_y, box_width,
//                              box_height
// result    strobe (1 cycle)   track_index, cost, degenerate, last
//
// Clear and append leave busy low. A score request reads the track memory one
// entry a cycle, and busy stays high until the last entry has passed the read
// port and the geometry stage that uses the latched detection box.
// Results leave a pipeline of IOU_FRAC_BITS + 6 stages (read, geometry,
// multiply, union, one divider stage per quotient bit, rounding), one a cycle.
// Synchronous reset empties the table; memory contents are not cleared.
// The result side is never stalled: each word shows for exactly one cycle.
`include "assert_macros.svh"

module iou_cost_matrix_core #(
  parameter int MAX_TRACKS    = 64,
  parameter int IOU_FRAC_BITS = 16
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  start,
  output logic                                  busy,
  input  logic [1:0]                            req_type,
  input  logic signed [iou_pkg::COORD_W-1:0]    center_x,
  input  logic signed [iou_pkg::COORD_W-1:0]    center_y,
  input  logic [iou_pkg::SIZE_W-1:0]            box_width,
  input  logic [iou_pkg::SIZE_W-1:0]            box_height,
  output logic                                  strobe,
  output logic [iou_pkg::INDEX_W-1:0]           track_index,
  output logic signed [iou_pkg::COST_W-1:0]     cost,
  output logic                                  degenerate,
  output logic                                  last
);
  import iou_pkg::*;

  localparam int IDX_W = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
  localparam int CNT_W = $clog2(MAX_TRACKS + 1);
  localparam int F     = IOU_FRAC_BITS;
  localparam int DIV_N = F + 1;
  localparam int QW    = F + 2;
  localparam int CW    = (QW > COST_W) ? QW : COST_W;

  // table state
  box_t             mem [MAX_TRACKS];
  logic [CNT_W-1:0] count;
  box_t             rd_data;

  // score sequencing
  logic             running;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_last;
  box_t             det;
  logic [AREA_W-1:0] det_area;

  // pipeline registers
  tag_t              s1_tag;
  tag_t              s2_tag;
  logic [SPAN_W-1:0] s2_iw;
  logic [SPAN_W-1:0] s2_ih;
  logic [AREA_W-1:0] s2_tarea;
  tag_t              s3_tag;
  logic [I4_W-1:0]   s3_i4;
  logic [U4_W-1:0]   s3_a4;
  tag_t              s4_tag;
  logic [I4_W-1:0]   s4_i4;
  logic [U4_W-1:0]   s4_u4;
  logic              s4_degen;

  // divider stages
  tag_t             dv_tag   [DIV_N];
  logic [U4_W-1:0]  dv_rem   [DIV_N];
  logic [F:0]       dv_q     [DIV_N];
  logic [U4_W-1:0]  dv_u4    [DIV_N];
  logic             dv_degen [DIV_N];

  logic accept;
  logic wr_en;
  box_t in_box;

  assign accept = start && !busy;
  assign busy   = running || s1_tag.valid || s2_tag.valid;
  assign in_box = '{cx: center_x, cy: center_y, w: box_width, h: box_height};
  assign wr_en  = accept && (req_type == REQ_APPEND) && (count < CNT_W'(MAX_TRACKS));
  assign rd_last = (CNT_W'(rd_idx) + CNT_W'(1)) == count;

  // decode requests, hold the table count and the scan pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      running <= 1'b0;
    end else if (accept) begin
      unique case (req_type)
        REQ_CLEAR:  count <= '0;
        REQ_APPEND: if (wr_en) count <= count + CNT_W'(1);
        REQ_SCORE:  running <= (count != '0);
        default:    ;
      endcase
    end else if (running && rd_last) begin
      running <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx <= '0;
    end else if (running) begin
      rd_idx <= rd_idx + IDX_W'(1);
    end
  end

  // latch the detection box and its area
  always_ff @(posedge clk) begin
    if (accept && (req_type == REQ_SCORE)) det <= in_box;
    det_area <= AREA_W'(det.w) * AREA_W'(det.h);
  end

  // track memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IDX_W-1:0]] <= in_box;
    rd_data <= mem[rd_idx];
  end

  // advance tags through the front stages
  always_ff @(posedge clk) begin
    s1_tag.idx  <= INDEX_W'(rd_idx);
    s1_tag.last <= rd_last;
    s2_tag.idx  <= s1_tag.idx;
    s2_tag.last <= s1_tag.last;
    s3_tag.idx  <= s2_tag.idx;
    s3_tag.last <= s2_tag.last;
    s4_tag.idx  <= s3_tag.idx;
    s4_tag.last <= s3_tag.last;
    if (rst) begin
      s1_tag.valid <= 1'b0;
      s2_tag.valid <= 1'b0;
      s3_tag.valid <= 1'b0;
      s4_tag.valid <= 1'b0;
    end else begin
      s1_tag.valid <= running;
      s2_tag.valid <= s1_tag.valid;
      s3_tag.valid <= s2_tag.valid;
      s4_tag.valid <= s3_tag.valid;
    end
  end

  // geometry, products and union
  always_ff @(posedge clk) begin
    s2_iw    <= overlap(span_lo(det.cx, det.w), span_hi(det.cx, det.w),
                        span_lo(rd_data.cx, rd_data.w), span_hi(rd_data.cx, rd_data.w));
    s2_ih    <= overlap(span_lo(det.cy, det.h), span_hi(det.cy, det.h),
                        span_lo(rd_data.cy, rd_data.h), span_hi(rd_data.cy, rd_data.h));
    s2_tarea <= AREA_W'(rd_data.w) * AREA_W'(rd_data.h);

    s3_i4 <= I4_W'(s2_iw) * I4_W'(s2_ih);
    s3_a4 <= {(AREA_W + 1)'(det_area) + (AREA_W + 1)'(s2_tarea), 2'b00};

    s4_i4    <= s3_i4;
    s4_u4    <= s3_a4 - U4_W'(s3_i4);
    s4_degen <= (s3_a4 == U4_W'(s3_i4));
  end

  // restoring divider, one quotient bit per stage; the overlap never exceeds
  // the union, so the first stage needs no shift
  for (genvar j = 0; j < DIV_N; j++) begin : g_div
    tag_t            in_tag;
    logic [U4_W:0]   trial;
    logic [F:0]      in_q;
    logic [U4_W-1:0] in_u4;
    logic            in_degen;
    logic            ge;

    if (j == 0) begin : g_first
      assign in_tag   = s4_tag;
      assign trial    = (U4_W + 1)'(s4_i4);
      assign in_q     = '0;
      assign in_u4    = s4_u4;
      assign in_degen = s4_degen;
    end else begin : g_rest
      assign in_tag   = dv_tag[j-1];
      assign trial    = {dv_rem[j-1], 1'b0};
      assign in_q     = dv_q[j-1];
      assign in_u4    = dv_u4[j-1];
      assign in_degen = dv_degen[j-1];
    end

    assign ge = trial >= {1'b0, in_u4};

    always_ff @(posedge clk) begin
      dv_tag[j].idx  <= in_tag.idx;
      dv_tag[j].last <= in_tag.last;
      if (rst) begin
        dv_tag[j].valid <= 1'b0;
      end else begin
        dv_tag[j].valid <= in_tag.valid;
      end
    end

    always_ff @(posedge clk) begin
      dv_rem[j]      <= ge ? U4_W'(trial - {1'b0, in_u4}) : U4_W'(trial);
      dv_q[j]        <= {in_q[F-1:0], ge};
      dv_u4[j]       <= in_u4;
      dv_degen[j]    <= in_degen;
    end
  end

  // round to nearest (ties up), negate and drive the result word
  logic          round_up;
  logic [QW-1:0] q_round;
  logic [CW-1:0] q_neg;

  assign round_up = {dv_rem[DIV_N-1], 1'b0} >= {1'b0, dv_u4[DIV_N-1]};
  assign q_round  = QW'(dv_q[DIV_N-1]) + QW'(round_up);
  assign q_neg    = CW'(0) - CW'(q_round);

  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= dv_tag[DIV_N-1].valid;
    end
  end

  always_ff @(posedge clk) begin
    track_index <= dv_tag[DIV_N-1].idx;
    last        <= dv_tag[DIV_N-1].last;
    degenerate  <= dv_degen[DIV_N-1];
    cost        <= dv_degen[DIV_N-1] ? '0 : $signed(q_neg[COST_W-1:0]);
  end

  // checks
  `ASSERT_IMPLIES(a_scan_nonempty, clk, rst, running, count != '0, "scan with empty table")
  `ASSERT_NEXT(a_scan_stops, clk, rst, running && rd_last, !running, "scan ran past last entry")
  `ASSERT_NEXT(a_score_starts, clk, rst, accept && (req_type == REQ_SCORE) && (count != '0),
               running, "score request did not start a scan")
  `ASSERT_IMPLIES(a_degen_zero, clk, rst, strobe && degenerate, cost == '0,
                  "degenerate word with nonzero cost")

endmodule

[tb/iou_cost_matrix_core_tb.sv]
module iou_cost_matrix_core_tb;
  import iou_pkg::*;

  localparam int TRACK_CAP  = 64;
  localparam int FRAC       = 16;
  localparam int RAND_ITEMS = 350;
  localparam int QUIET_TAIL = 40;     // no idle gaps among the last words
  localparam int WDOG_LIMIT = 4000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct {
    logic [1:0] req;
    box_t       box;
    bit         drain;   // hold this word until all costs have come back
  } req_word_t;

  typedef struct {
    logic [INDEX_W-1:0]        idx;
    logic signed [COST_W-1:0]  cost;
    logic                      degen;
    logic                      last;
  } cost_word_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] req_type = REQ_CLEAR;
  logic signed [COORD_W-1:0] center_x = '0;
  logic signed [COORD_W-1:0] center_y = '0;
  logic [SIZE_W-1:0] box_width = '0;
  logic [SIZE_W-1:0] box_height = '0;
  logic strobe;
  logic [INDEX_W-1:0] track_index;
  logic signed [COST_W-1:0] cost;
  logic degenerate;
  logic last;

  req_word_t  pending_q[$];
  cost_word_t cost_q[$];

  // scoreboard copy of the track table
  box_t trk_boxes[TRACK_CAP];
  int   trk_count = 0;

  // generator's own view of the table, used to aim detections at tracks
  box_t gen_boxes[TRACK_CAP];
  int   gen_count = 0;
  int   gen_counted = 0;

  int total_words = 0;
  int accepted_cnt = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int gap_left = 0;
  bit idle_on = 1'b1;

  iou_cost_matrix_core #(
    .MAX_TRACKS   (TRACK_CAP),
    .IOU_FRAC_BITS(FRAC)
  ) u_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .req_type   (req_type),
    .center_x   (center_x),
    .center_y   (center_y),
    .box_width  (box_width),
    .box_height (box_height),
    .strobe     (strobe),
    .track_index(track_index),
    .cost       (cost),
    .degenerate (degenerate),
    .last       (last)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // negated IoU of a detection against one track, doubled coordinates
  function automatic void iou_cost(input box_t d, input box_t t,
                                   output logic signed [COST_W-1:0] c, output logic dg);
    longint dl, dr, db, dt, tl, tr, tb, tt;
    longint iw, ih, i4, u4, q;
    dl = 2 * longint'($signed(d.cx)) - longint'(d.w);
    dr = 2 * longint'($signed(d.cx)) + longint'(d.w);
    db = 2 * longint'($signed(d.cy)) - longint'(d.h);
    dt = 2 * longint'($signed(d.cy)) + longint'(d.h);
    tl = 2 * longint'($signed(t.cx)) - longint'(t.w);
    tr = 2 * longint'($signed(t.cx)) + longint'(t.w);
    tb = 2 * longint'($signed(t.cy)) - longint'(t.h);
    tt = 2 * longint'($signed(t.cy)) + longint'(t.h);
    iw = ((dr < tr) ? dr : tr) - ((dl > tl) ? dl : tl);
    ih = ((dt < tt) ? dt : tt) - ((db > tb) ? db : tb);
    if (iw < 0) iw = 0;
    if (ih < 0) ih = 0;
    i4 = iw * ih;
    u4 = 4 * (longint'(d.w) * longint'(d.h) + longint'(t.w) * longint'(t.h)) - i4;
    if (u4 == 0) begin
      c  = '0;
      dg = 1'b1;
    end else begin
      q  = ((i4 <<< FRAC) + u4 / 2) / u4;
      c  = COST_W'(-q);
      dg = 1'b0;
    end
  endfunction

  // update the table copy and queue the costs one request produces
  task automatic predict_costs(input req_word_t w);
    logic signed [COST_W-1:0] c;
    logic dg;
    case (w.req)
      REQ_CLEAR: trk_count = 0;
      REQ_APPEND: begin
        if (trk_count < TRACK_CAP) begin
          trk_boxes[trk_count] = w.box;
          trk_count++;
        end
      end
      REQ_SCORE: begin
        for (int k = 0; k < trk_count; k++) begin
          iou_cost(w.box, trk_boxes[k], c, dg);
          cost_q.push_back('{idx: INDEX_W'(k), cost: c, degen: dg,
                             last: (k == trk_count - 1)});
        end
      end
      default: ;
    endcase
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", msg);
  endtask

  function automatic box_t mk_box(input int cx, input int cy, input int w, input int h);
    box_t b;
    b.cx = COORD_W'(cx);
    b.cy = COORD_W'(cy);
    b.w  = SIZE_W'(w);
    b.h  = SIZE_W'(h);
    return b;
  endfunction

  function automatic int clamp(input int v, input int lo, input int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int pick_coord();
    case ($urandom_range(0, 9))
      0: return int'($urandom_range(0, 16383)) - 8192;
      1: return -4096;
      2: return 8191;
      default: return int'($urandom_range(0, 12287)) - 4096;
    endcase
  endfunction

  function automatic int pick_size();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 4095;
      2, 3, 4: return $urandom_range(0, 4095);
      default: return $urandom_range(1, 200);
    endcase
  endfunction

  function automatic box_t rand_box();
    return mk_box(pick_coord(), pick_coord(), pick_size(), pick_size());
  endfunction

  // jitter a box so that it overlaps its source most of the time
  function automatic box_t near_box(input box_t t);
    int dx, dy;
    dx = int'(t.w) / 2 + 3;
    dy = int'(t.h) / 2 + 3;
    return mk_box(clamp(int'($signed(t.cx)) + int'($urandom_range(0, 2 * dx)) - dx, -8192, 8191),
                  clamp(int'($signed(t.cy)) + int'($urandom_range(0, 2 * dy)) - dy, -8192, 8191),
                  clamp(int'(t.w) + int'($urandom_range(0, 2 * dx)) - dx, 0, 4095),
                  clamp(int'(t.h) + int'($urandom_range(0, 2 * dy)) - dy, 0, 4095));
  endfunction

  // queue one request word and track what the table will hold
  task automatic queue_req(input logic [1:0] rq, input box_t b, input bit drain);
    pending_q.push_back('{req: rq, box: b, drain: drain});
    case (rq)
      REQ_CLEAR: begin
        gen_count = 0;
        gen_counted++;
      end
      REQ_APPEND: begin
        if (gen_count < TRACK_CAP) begin
          gen_boxes[gen_count] = b;
          gen_count++;
          gen_counted++;
        end
      end
      REQ_SCORE: gen_counted++;
      default: ;
    endcase
  endtask

  // stimulus, then wait for the pipeline to empty and report
  initial begin
    box_t anchor;
    box_t det;
    int n_app;
    int n_score;

    // directed: extremes, every request, empty and degenerate cases
    queue_req(REQ_SCORE,  mk_box(0, 0, 10, 10), 1'b0);
    queue_req(REQ_APPEND, mk_box(0, 0, 10, 10), 1'b0);
    queue_req(REQ_APPEND, mk_box(8191, 8191, 4095, 4095), 1'b0);
    queue_req(REQ_APPEND, mk_box(-8192, -8192, 4095, 4095), 1'b0);
    queue_req(REQ_APPEND, mk_box(-4096, -4096, 1, 1), 1'b0);
    queue_req(REQ_APPEND, mk_box(100, -100, 0, 0), 1'b0);
    queue_req(REQ_APPEND, mk_box(100, -100, 0, 50), 1'b0);
    queue_req(REQ_APPEND, mk_box(5, 0, 10, 10), 1'b0);
    queue_req(REQ_SCORE,  mk_box(0, 0, 10, 10), 1'b0);
    queue_req(REQ_SCORE,  mk_box(100, -100, 0, 0), 1'b0);
    queue_req(REQ_SCORE,  mk_box(8191, 8191, 4095, 4095), 1'b0);
    queue_req(REQ_SCORE,  mk_box(-8192, -8192, 4095, 4095), 1'b1);
    queue_req(REQ_UNUSED, rand_box(), 1'b0);
    queue_req(REQ_SCORE,  mk_box(5, 3, 11, 9), 1'b0);
    queue_req(REQ_CLEAR,  rand_box(), 1'b0);
    queue_req(REQ_SCORE,  mk_box(0, 0, 10, 10), 1'b0);
    queue_req(REQ_APPEND, mk_box(-1, -1, 4095, 0), 1'b0);
    queue_req(REQ_SCORE,  mk_box(-1, -1, 4095, 0), 1'b0);
    queue_req(REQ_APPEND, mk_box(2, 2, 7, 7), 1'b0);
    queue_req(REQ_SCORE,  mk_box(2, 2, 8, 7), 1'b0);
    queue_req(REQ_CLEAR,  rand_box(), 1'b0);

    // random frames: usually a clear, then a batch of tracks and a few detections; some stray words
    gen_counted = 0;
    while (gen_counted < RAND_ITEMS) begin
      case ($urandom_range(0, 15))
        0: queue_req(REQ_UNUSED, rand_box(), 1'b0);
        1: queue_req(2'($urandom_range(0, 3)), rand_box(), 1'b0);
        default: begin
          if ($urandom_range(0, 4) != 0) queue_req(REQ_CLEAR, rand_box(), 1'b0);
          case ($urandom_range(0, 9))
            7, 8: n_app = $urandom_range(11, 63);
            9: n_app = $urandom_range(60, 70);
            default: n_app = $urandom_range(1, 10);
          endcase
          anchor = rand_box();
          for (int i = 0; i < n_app; i++)
            queue_req(REQ_APPEND, ($urandom_range(0, 4) != 0) ? near_box(anchor) : rand_box(),
                      1'b0);
          n_score = $urandom_range(1, 4);
          for (int i = 0; i < n_score; i++) begin
            case ($urandom_range(0, 19))
              0, 1, 2, 3, 4: det = rand_box();
              5, 6, 7: begin
                det = rand_box();
                if ($urandom_range(0, 1) != 0) det.w = '0;
                else det.h = '0;
              end
              default: det = (gen_count > 0) ?
                             near_box(gen_boxes[$urandom_range(0, gen_count - 1)]) : rand_box();
            endcase
            queue_req(REQ_SCORE, det, $urandom_range(0, 19) == 0);
          end
        end
      endcase
    end
    total_words = pending_q.size();

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    while (accepted_cnt != total_words) @(negedge clk);
    while (cost_q.size() != 0) @(negedge clk);
    repeat (FRAC + 16) @(posedge clk);
    if (cost_q.size() != 0) report_mismatch("costs still expected at end of run");
    if (mismatches == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

  // request driver: present the next word once the current one is taken
  always @(posedge clk) begin
    req_word_t w;
    if (rst) begin
      start <= 1'b0;
      gap_left = 0;
    end else if (!start || !busy) begin
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
      end else if (pending_q.size() == 0 ||
                   (pending_q[0].drain && (start || cost_q.size() != 0))) begin
        start <= 1'b0;
      end else begin
        w = pending_q.pop_front();
        req_type   <= w.req;
        center_x   <= w.box.cx;
        center_y   <= w.box.cy;
        box_width  <= w.box.w;
        box_height <= w.box.h;
        start      <= 1'b1;
        if ($urandom_range(0, 31) == 0) idle_on = !idle_on;
        if (idle_on && pending_q.size() > QUIET_TAIL && $urandom_range(0, 3) == 0)
          gap_left = $urandom_range(1, 18);
      end
    end
  end

  // monitor: predict on each accepted request, check each cost word
  always @(posedge clk) begin
    cost_word_t exp_w;
    if (!rst) begin
      if (start && !busy) begin
        predict_costs('{req: req_type,
                        box: mk_box(int'(center_x), int'(center_y),
                                    int'(box_width), int'(box_height)),
                        drain: 1'b0});
        accepted_cnt++;
      end
      if (strobe) begin
        if (cost_q.size() == 0) begin
          report_mismatch($sformatf("unexpected word: idx %0d cost %0d degen %0b last %0b",
                                    track_index, cost, degenerate, last));
        end else begin
          exp_w = cost_q.pop_front();
          if (track_index !== exp_w.idx || cost !== exp_w.cost ||
              degenerate !== exp_w.degen || last !== exp_w.last)
            report_mismatch($sformatf(
              "idx exp %0d got %0d, cost exp %0d got %0d, degen exp %0b got %0b, last exp %0b got %0b",
              exp_w.idx, track_index, exp_w.cost, cost, exp_w.degen, degenerate,
              exp_w.last, last));
        end
      end
    end
  end

  // watchdog: end the run if nothing moves for too long
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WDOG_LIMIT) begin
        $display("CHECK FAILED");
        $finish;
      end
    end
  end

endmodule

[files.f]
+incdir+hdl
hdl/iou_pkg.sv
hdl/iou_cost_matrix_core.sv
tb/iou_cost_matrix_core_tb.sv
